[rtl/jsu_pkg.sv]
// jsu_pkg: shared types and constants of the json string unescaper
// holds the job record passed from the front end through the queue to the back end
// no dependencies
`default_nettype none

package jsu_pkg;

    // configuration register
    localparam int unsigned BUF_SIZE_W = 17;
    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 17'd256;

    // final status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TYPE  = 2'd1;
    localparam logic [1:0] ST_PARSE = 2'd2;
    localparam logic [1:0] ST_SMALL = 2'd3;

    // job queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    // results caused by one input byte: up to three data bytes, then an optional status
    typedef struct packed {
        logic [1:0]      ndata;
        logic [2:0][7:0] bytes;
        logic            has_status;
        logic [1:0]      st;
    } job_t;

endpackage

`default_nettype wire

[rtl/jsu_front.sv]
// jsu_front: takes source bytes, tracks the string state and builds one job per byte that causes results
// depends on jsu_pkg
`default_nettype none

module jsu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          start_req,
    input  wire logic [jsu_pkg::BUF_SIZE_W-1:0] buffer_size,
    input  wire logic                          q_full,
    output logic                               push,
    output jsu_pkg::job_t                      push_job
);

    localparam logic [2:0] MODE_QUOTE = 3'd0;
    localparam logic [2:0] MODE_STR   = 3'd1;
    localparam logic [2:0] MODE_ESC   = 3'd2;
    localparam logic [2:0] MODE_HEX   = 3'd3;
    localparam logic [2:0] MODE_DONE  = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    localparam int unsigned BW = jsu_pkg::BUF_SIZE_W;

    logic [2:0]    mode_reg, mode_next, mode_cur;
    logic [1:0]    cnt_reg, cnt_next, cnt_cur;
    logic [15:0]   cp_reg, cp_next, cp_cur, cp_new;
    logic [BW-1:0] bw_reg, bw_next, bw_cur;
    logic [BW-1:0] cap;
    logic          room1, room2, room3;
    logic          accept;
    logic          esc_hit, esc_done;
    logic [7:0]    esc_byte;
    logic          hex_ok;
    logic [3:0]    hex_val;
    logic [7:0]    c_dig, c_low, c_up;
    jsu_pkg::job_t job;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;

    // capacity is one less than the buffer size, a zero size counts as one
    assign cap = (buffer_size == '0) ? '0 : buffer_size - BW'(1);

    assign mode_cur = start_req ? MODE_QUOTE : mode_reg;
    assign cnt_cur  = start_req ? 2'd0 : cnt_reg;
    assign cp_cur   = start_req ? 16'd0 : cp_reg;
    assign bw_cur   = start_req ? '0 : bw_reg;

    assign room1 = bw_cur < cap;
    assign room2 = ({1'b0, bw_cur} + (BW+1)'(1)) < {1'b0, cap};
    assign room3 = ({1'b0, bw_cur} + (BW+1)'(2)) < {1'b0, cap};

    // hex digit decode
    assign c_dig = data_byte - 8'h30;
    assign c_low = data_byte - 8'h57;
    assign c_up  = data_byte - 8'h37;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        priority if (data_byte >= 8'h30 && data_byte <= 8'h39)
            hex_val = c_dig[3:0];
        else if (data_byte >= 8'h61 && data_byte <= 8'h66)
            hex_val = c_low[3:0];
        else if (data_byte >= 8'h41 && data_byte <= 8'h46)
            hex_val = c_up[3:0];
        else
            hex_ok = 1'b0;
    end

    assign cp_new = {cp_cur[11:0], hex_val};

    always_comb
    begin
        mode_next = mode_cur;
        cnt_next  = cnt_cur;
        cp_next   = cp_cur;
        bw_next   = bw_cur;
        job       = '0;
        job.st    = jsu_pkg::ST_OK;
        esc_hit   = 1'b0;
        esc_done  = 1'b0;
        esc_byte  = 8'h00;

        unique case (mode_cur)
            MODE_QUOTE:
            begin
                if (data_byte == CH_QUOTE)
                    mode_next = MODE_STR;
                else
                begin
                    job.has_status = 1'b1;
                    job.st         = jsu_pkg::ST_TYPE;
                    mode_next      = MODE_DONE;
                end
            end
            MODE_STR:
            begin
                priority if (data_byte == CH_NUL)
                begin
                    job.has_status = 1'b1;
                    job.st         = jsu_pkg::ST_PARSE;
                    mode_next      = MODE_DONE;
                end
                else if (data_byte == CH_QUOTE)
                begin
                    job.has_status = 1'b1;
                    job.st         = jsu_pkg::ST_OK;
                    mode_next      = MODE_DONE;
                end
                else if (data_byte == CH_BSL)
                    mode_next = MODE_ESC;
                else if (room1)
                begin
                    job.ndata    = 2'd1;
                    job.bytes[0] = data_byte;
                    bw_next      = bw_cur + BW'(1);
                end
                else
                begin
                    job.has_status = 1'b1;
                    job.st         = jsu_pkg::ST_SMALL;
                    mode_next      = MODE_DONE;
                end
            end
            MODE_ESC:
            begin
                mode_next = MODE_STR;
                unique case (data_byte)
                    8'h6E:    begin esc_hit = 1'b1; esc_byte = 8'h0A;    end // n
                    8'h72:    begin esc_hit = 1'b1; esc_byte = 8'h0D;    end // r
                    8'h74:    begin esc_hit = 1'b1; esc_byte = 8'h09;    end // t
                    CH_QUOTE: begin esc_hit = 1'b1; esc_byte = CH_QUOTE; end
                    CH_BSL:   begin esc_hit = 1'b1; esc_byte = CH_BSL;   end
                    CH_SLASH: begin esc_hit = 1'b1; esc_byte = CH_SLASH; end
                    8'h62:    begin esc_hit = 1'b1; esc_byte = 8'h08;    end // b
                    8'h66:    begin esc_hit = 1'b1; esc_byte = 8'h0C;    end // f
                    8'h75:                                                   // u
                    begin
                        mode_next = MODE_HEX;
                        cnt_next  = 2'd0;
                        cp_next   = 16'd0;
                    end
                    default:
                    begin
                        job.has_status = 1'b1;
                        job.st         = jsu_pkg::ST_PARSE;
                        mode_next      = MODE_DONE;
                    end
                endcase
                if (esc_hit)
                begin
                    esc_done = 1'b1;
                    if (room1)
                    begin
                        job.ndata    = 2'd1;
                        job.bytes[0] = esc_byte;
                        bw_next      = bw_cur + BW'(1);
                    end
                end
            end
            MODE_HEX:
            begin
                if (!hex_ok)
                begin
                    job.has_status = 1'b1;
                    job.st         = jsu_pkg::ST_PARSE;
                    mode_next      = MODE_DONE;
                end
                else
                begin
                    cp_next = cp_new;
                    if (cnt_cur == 2'd3)
                    begin
                        cnt_next  = 2'd0;
                        mode_next = MODE_STR;
                        esc_done  = 1'b1;
                        // surrogates collapse to a question mark
                        priority if (cp_new[15:11] == 5'b11011)
                        begin
                            if (room1)
                            begin
                                job.ndata    = 2'd1;
                                job.bytes[0] = CH_QMARK;
                                bw_next      = bw_cur + BW'(1);
                            end
                        end
                        else if (cp_new[15:7] == 9'd0)
                        begin
                            if (room1)
                            begin
                                job.ndata    = 2'd1;
                                job.bytes[0] = cp_new[7:0];
                                bw_next      = bw_cur + BW'(1);
                            end
                        end
                        else if (cp_new[15:11] == 5'd0)
                        begin
                            if (room2)
                            begin
                                job.ndata    = 2'd2;
                                job.bytes[0] = {3'b110, cp_new[10:6]};
                                job.bytes[1] = {2'b10, cp_new[5:0]};
                                bw_next      = bw_cur + BW'(2);
                            end
                        end
                        else
                        begin
                            if (room3)
                            begin
                                job.ndata    = 2'd3;
                                job.bytes[0] = {4'b1110, cp_new[15:12]};
                                job.bytes[1] = {2'b10, cp_new[11:6]};
                                job.bytes[2] = {2'b10, cp_new[5:0]};
                                bw_next      = bw_cur + BW'(3);
                            end
                        end
                    end
                    else
                        cnt_next = cnt_cur + 2'd1;
                end
            end
            default:
            begin
                // finished: bytes are dropped until the next start
            end
        endcase

        // a completed escape with the buffer now full ends the run
        if (esc_done && bw_next >= cap)
        begin
            job.has_status = 1'b1;
            job.st         = jsu_pkg::ST_SMALL;
            mode_next      = MODE_DONE;
        end
    end

    assign push     = accept && (job.ndata != 2'd0 || job.has_status);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_QUOTE;
            cnt_reg  <= 2'd0;
            cp_reg   <= 16'd0;
            bw_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            cp_reg   <= cp_next;
            bw_reg   <= bw_next;
        end
    end

`ifndef SYNTH
    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_job.has_status) |=> (mode_reg == MODE_DONE))
        else $error("status pushed but run not finished");
    a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start_req && mode_reg == MODE_DONE) |-> !push)
        else $error("job pushed after final status");
`endif

endmodule

`default_nettype wire

[rtl/jsu_queue.sv]
// jsu_queue: short job queue in flip-flops between front and back end
// depends on jsu_pkg
`default_nettype none

module jsu_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jsu_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output jsu_pkg::job_t      q_job
);

    jsu_pkg::job_t                  slot_reg [jsu_pkg::Q_DEPTH];
    logic [jsu_pkg::Q_PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [jsu_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                           do_pop;

    assign full    = (cnt_reg == jsu_pkg::Q_CNT_W'(jsu_pkg::Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_job   = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
            cnt_next = cnt_reg + jsu_pkg::Q_CNT_W'(1);
        else if (!push && do_pop)
            cnt_next = cnt_reg - jsu_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + jsu_pkg::Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + jsu_pkg::Q_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != jsu_pkg::Q_CNT_W'(jsu_pkg::Q_DEPTH))
            |-> (jsu_pkg::Q_PTR_W'(wr_ptr_reg - rd_ptr_reg) == cnt_reg[jsu_pkg::Q_PTR_W-1:0]))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

[rtl/jsu_back.sv]
// jsu_back: unpacks jobs into single results and holds them in the output register
// depends on jsu_pkg
`default_nettype none

module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire jsu_pkg::job_t q_job,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               is_status,
    output logic [1:0]         status,
    output logic               last
);

    jsu_pkg::job_t cur_reg;
    logic          cur_valid_reg, cur_valid_next;
    logic [1:0]    pos_reg, pos_next;
    logic [2:0]    total;
    logic          cur_last, out_free, advance, cur_done;
    logic [7:0]    sel_byte;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          is_status_reg;
    logic [1:0]    status_reg;
    logic          last_reg;

    assign total    = {1'b0, cur_reg.ndata} + {2'b00, cur_reg.has_status};
    assign cur_last = ({1'b0, pos_reg} + 3'd1) == total;
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = cur_valid_reg && out_free;
    assign cur_done = advance && cur_last;
    assign pop      = q_valid && (!cur_valid_reg || cur_done);

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    sel_byte = cur_reg.bytes[0];
            2'd1:    sel_byte = cur_reg.bytes[1];
            2'd2:    sel_byte = cur_reg.bytes[2];
            default: sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            pos_next       = 2'd0;
        end
        else if (cur_done)
            cur_valid_next = 1'b0;
        else if (advance)
            pos_next = pos_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_job;
        if (advance)
        begin
            last_reg <= cur_last;
            if (pos_reg < cur_reg.ndata)
            begin
                out_byte_reg  <= sel_byte;
                is_status_reg <= 1'b0;
                status_reg    <= jsu_pkg::ST_OK;
            end
            else
            begin
                out_byte_reg  <= 8'h00;
                is_status_reg <= 1'b1;
                status_reg    <= cur_reg.st;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_status = is_status_reg;
    assign status    = status_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_pos_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> ({1'b0, pos_reg} < total))
        else $error("result index beyond job");
`endif

endmodule

`default_nettype wire

[rtl/json_string_unescape.sv]
// json_string_unescape: top level, front end, job queue and back end
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
// path: the results of a byte pass a queue slot, the back end's job register and the output register
// throughput: one byte per cycle while each byte causes at most one result and out_stall is low;
//   a byte with more results holds the back end, which has a single output register
// reset: buffer size 256, string state waits for an opening quote, queue and output empty
`default_nettype none

module json_string_unescape (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // source byte channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     data_byte,
    input  wire logic                           start_req,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          out_byte,
    output logic                                is_status,
    output logic [1:0]                          status,
    output logic                                last,
    // buffer size register
    input  wire logic                           cfg_wr_en,
    input  wire logic [jsu_pkg::BUF_SIZE_W-1:0] cfg_wr_data
);

    logic [jsu_pkg::BUF_SIZE_W-1:0] buffer_size_reg;
    logic                           push, q_full, q_valid, pop;
    jsu_pkg::job_t                  push_job, q_job;

    // buffer size, capacity is one less
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buffer_size_reg <= jsu_pkg::BUF_SIZE_RESET;
        else if (cfg_wr_en)
            buffer_size_reg <= cfg_wr_data;
    end

    // front end: string state, one job per transfer that causes results
    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .start_req   (start_req),
        .buffer_size (buffer_size_reg),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    // queue lets bursts of up to four jobs drain while new bytes come in
    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    // back end: one result per cycle into the output register while the output is not stalled
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .is_status (is_status),
        .status    (status),
        .last      (last)
    );

`ifndef SYNTH
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_status) |-> last)
        else $error("status result not marked last");
`endif

endmodule

`default_nettype wire

[verif/json_string_unescape_tb.sv]
// json_string_unescape_tb: self-checking testbench for the json string unescaper
// predicts every result from its own scanner model and checks each result transfer in order
// depends on jsu_pkg and json_string_unescape
`timescale 1ns / 100ps

module json_string_unescape_tb;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 37;
    localparam int HOLD_CYCLES     = 150;
    // a result passes the queue, the back end and the output register; allow a margin after draining
    localparam int CFG_SETTLE  = 8;
    localparam int END_SETTLE  = 12;
    // longest quiet stretch of a correct run: receiver hold plus a sender gap and a pause
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [2:0] {
        WAIT_QUOTE,
        IN_STRING,
        AFTER_BACKSLASH,
        IN_HEX,
        FINISHED
    } scan_mode_e;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_st;
        logic [1:0] st;
        logic       lst;
    } result_t;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       counts;
    } src_item_t;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_ONE,
        ROW_NONE
    } row_kind_e;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        row_kind_e  kind;
        result_t    res;
    } stim_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [7:0]                     data_byte;
    logic                           start_req;
    logic                           out_valid;
    logic                           out_stall;
    logic [7:0]                     out_byte;
    logic                           is_status;
    logic [1:0]                     status;
    logic                           last;
    logic                           cfg_wr_en;
    logic [jsu_pkg::BUF_SIZE_W-1:0] cfg_wr_data;

    // scanner model state
    scan_mode_e                     scan_mode = WAIT_QUOTE;
    int                             hex_count = 0;
    logic [15:0]                    code_pt = '0;
    int                             written = 0;
    logic [jsu_pkg::BUF_SIZE_W-1:0] buf_size = jsu_pkg::BUF_SIZE_RESET;

    result_t   step_results[$];
    result_t   predicted_results[$];
    row_kind_e row_kinds[$];
    result_t   row_results[$];
    src_item_t pending[$];

    int   errors = 0;
    int   quiet = 0;
    int   items_sent = 0;
    int   burst_left = 0;
    logic hold_request = 1'b0;

    logic [7:0] esc_letters [8] = '{"n", "r", "t", "\"", "\\", "/", "b", "f"};
    logic [jsu_pkg::BUF_SIZE_W-1:0] buf_settings [9] = '{
        17'd3, 17'd0, 17'd1, 17'd2, 17'd5, 17'd65536, 17'h1FFFF, 17'd4, 17'd256
    };

    json_string_unescape i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .start_req   (start_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .is_status   (is_status),
        .status      (status),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------- scanner model

    function automatic int capacity();
        return (buf_size == 0) ? 0 : int'(buf_size) - 1;
    endfunction

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic result_t data_result(input logic [7:0] b);
        return '{byte_val: b, is_st: 1'b0, st: jsu_pkg::ST_OK, lst: 1'b1};
    endfunction

    function automatic result_t status_result(input logic [1:0] s);
        return '{byte_val: 8'h00, is_st: 1'b1, st: s, lst: 1'b1};
    endfunction

    task automatic add_data(input logic [7:0] b);
        result_t r;
        r = data_result(b);
        r.lst = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic add_status(input logic [1:0] s);
        result_t r;
        r = status_result(s);
        r.lst = 1'b0;
        step_results.push_back(r);
        scan_mode = FINISHED;
    endtask

    // one byte, dropped silently without room
    task automatic put_one(input logic [7:0] b);
        if (written < capacity())
        begin
            add_data(b);
            written++;
        end
    endtask

    // works out the results of one accepted source byte and queues them
    task automatic unescape_byte(input logic [7:0] c, input logic restart);
        logic esc_done;
        int   digit;
        esc_done = 1'b0;
        step_results.delete();
        if (restart)
        begin
            scan_mode = WAIT_QUOTE;
            hex_count = 0;
            code_pt   = '0;
            written   = 0;
        end
        case (scan_mode)
            WAIT_QUOTE:
                if (c == CH_QUOTE)
                    scan_mode = IN_STRING;
                else
                    add_status(jsu_pkg::ST_TYPE);
            IN_STRING:
                if (c == 8'h00)
                    add_status(jsu_pkg::ST_PARSE);
                else if (c == CH_QUOTE)
                    add_status(jsu_pkg::ST_OK);
                else if (c == CH_BACKSLASH)
                    scan_mode = AFTER_BACKSLASH;
                else if (written < capacity())
                    put_one(c);
                else
                    add_status(jsu_pkg::ST_SMALL);
            AFTER_BACKSLASH:
            begin
                scan_mode = IN_STRING;
                esc_done  = 1'b1;
                case (c)
                    "n":  put_one(8'h0A);
                    "r":  put_one(8'h0D);
                    "t":  put_one(8'h09);
                    "\"": put_one(CH_QUOTE);
                    "\\": put_one(CH_BACKSLASH);
                    "/":  put_one("/");
                    "b":  put_one(8'h08);
                    "f":  put_one(8'h0C);
                    "u":
                    begin
                        scan_mode = IN_HEX;
                        hex_count = 0;
                        code_pt   = '0;
                        esc_done  = 1'b0;
                    end
                    default:
                    begin
                        esc_done = 1'b0;
                        add_status(jsu_pkg::ST_PARSE);
                    end
                endcase
            end
            IN_HEX:
            begin
                digit = hex_digit_value(c);
                if (digit < 0)
                    add_status(jsu_pkg::ST_PARSE);
                else
                begin
                    code_pt = {code_pt[11:0], digit[3:0]};
                    if (hex_count == 3)
                    begin
                        hex_count = 0;
                        scan_mode = IN_STRING;
                        esc_done  = 1'b1;
                        // surrogates collapse to a question mark, multi-byte needs full room
                        if (code_pt >= 16'hD800 && code_pt <= 16'hDFFF)
                            put_one("?");
                        else if (code_pt < 16'h0080)
                            put_one(code_pt[7:0]);
                        else if (code_pt < 16'h0800)
                        begin
                            if (written + 1 < capacity())
                            begin
                                add_data(8'hC0 | code_pt[10:6]);
                                add_data(8'h80 | code_pt[5:0]);
                                written += 2;
                            end
                        end
                        else if (written + 2 < capacity())
                        begin
                            add_data(8'hE0 | code_pt[15:12]);
                            add_data(8'h80 | code_pt[11:6]);
                            add_data(8'h80 | code_pt[5:0]);
                            written += 3;
                        end
                    end
                    else
                        hex_count++;
                end
            end
            default:
                ;
        endcase
        if (esc_done && written >= capacity())
            add_status(jsu_pkg::ST_SMALL);
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].lst = 1'b1;
        foreach (step_results[i])
            predicted_results.push_back(step_results[i]);
    endtask

    // ---------------------------------------------------------------- monitor

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t   want;
        result_t   got;
        row_kind_e kind;
        logic      in_xfer;
        logic      out_xfer;
        if (rst_n)
        begin
            in_xfer  = in_valid && !in_stall;
            out_xfer = out_valid && !out_stall;
            if (in_xfer)
            begin
                unescape_byte(data_byte, start_req);
                // directed rows with a typed-in result
                if (row_kinds.size() != 0)
                begin
                    kind = row_kinds.pop_front();
                    want = row_results.pop_front();
                    got  = (step_results.size() > 0) ? step_results[0] : result_t'('0);
                    if ((kind == ROW_NONE && step_results.size() != 0) ||
                        (kind == ROW_ONE && (step_results.size() != 1 || got != want)))
                    begin
                        $display("%0t: row result expected %h (%s) actual %h (%0d results)",
                                 $time, want, kind.name(), got, step_results.size());
                        errors++;
                    end
                end
            end
            if (cfg_wr_en)
                buf_size = cfg_wr_data;
            if (out_xfer)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result byte %h is_status %b status %0d last %b",
                             $time, out_byte, is_status, status, last);
                    errors++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("out_byte", want.byte_val, out_byte);
                    check_field("is_status", 8'(want.is_st), 8'(is_status));
                    check_field("status", 8'(want.st), 8'(status));
                    check_field("last", 8'(want.lst), 8'(last));
                end
            end
            quiet = (in_xfer || out_xfer) ? 0 : quiet + 1;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet, predicted_results.size());
                $display("json_string_unescape verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    initial
    begin : receiver
        int seg_kind;
        int seg_len;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                // long hold-off so that the block fills and stalls its input
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
            begin
                seg_kind = $urandom_range(0, 3);
                seg_len  = $urandom_range(4, 40);
                repeat (seg_len)
                begin
                    case (seg_kind)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= 1'($urandom_range(0, 1));
                        2:       out_stall <= ($urandom_range(0, 3) == 0);
                        default: out_stall <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // valid stays high across a burst; a gap ends it
    task automatic send_byte(input logic [7:0] b, input logic restart);
        in_valid  <= 1'b1;
        data_byte <= b;
        start_req <= restart;
        do
            @(posedge clk);
        while (in_stall);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    // close: valid drops after the last transfer so that the block can go idle
    task automatic send_pending(input logic close);
        for (int i = 0; i < pending.size(); i++)
        begin
            if (close && i == pending.size() - 1)
                burst_left = 0;
            send_byte(pending[i].data, pending[i].restart);
            if (pending[i].counts)
                items_sent++;
        end
        pending.delete();
    endtask

    task automatic queue_item(input logic [7:0] b, input logic restart, input logic counts);
        pending.push_back('{data: b, restart: restart, counts: counts});
    endtask

    // backslash, u, then the good hex digits of cp (random case), then a breaking byte if fewer than four are good
    task automatic queue_unicode(input logic [15:0] cp, input int good, input logic [7:0] bad);
        logic [3:0] nib;
        queue_item(CH_BACKSLASH, 1'b0, 1'b1);
        queue_item("u", 1'b0, 1'b1);
        for (int i = 0; i < good; i++)
        begin
            nib = cp[15 - 4 * i -: 4];
            if (nib < 10)
                queue_item("0" + nib, 1'b0, 1'b1);
            else
                queue_item(8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10), 1'b0, 1'b1);
        end
        if (good < 4)
            queue_item(bad, 1'b0, 1'b1);
    endtask

    function automatic logic [15:0] random_code_point();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hFFFF));
            3:       return 16'($urandom_range(16'hD800, 16'hDFFF));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // mostly well-formed strings with random content, some broken ones, some noise
    task automatic build_string();
        int         kind;
        int         e;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            repeat ($urandom_range(1, 6))
                queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b1);
            return;
        end
        queue_item(CH_QUOTE, 1'b1, 1'b1);
        repeat ($urandom_range(0, 10))
        begin
            e = $urandom_range(0, 9);
            if (e < 4)
            begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_QUOTE || b == CH_BACKSLASH)
                    b = b ^ 8'h80;
                queue_item(b, 1'b0, 1'b1);
            end
            else if (e < 7)
            begin
                queue_item(CH_BACKSLASH, 1'b0, 1'b1);
                queue_item(esc_letters[$urandom_range(0, 7)], 1'b0, 1'b1);
            end
            else
                queue_unicode(random_code_point(), 4, 8'h00);
        end
        if (kind < 7)
            queue_item(CH_QUOTE, 1'b0, 1'b1);
        else
            case ($urandom_range(0, 3))
                0: queue_item(8'h00, 1'b0, 1'b1);
                1:
                begin
                    // unknown escape letter
                    b = 8'($urandom_range(0, 255));
                    case (b)
                        "n", "r", "t", "\"", "\\", "/", "b", "f", "u": b = "q";
                        default: ;
                    endcase
                    queue_item(CH_BACKSLASH, 1'b0, 1'b1);
                    queue_item(b, 1'b0, 1'b1);
                end
                2:
                begin
                    queue_item(CH_BACKSLASH, 1'b0, 1'b1);
                    queue_item(8'h00, 1'b0, 1'b1);
                end
                default:
                begin
                    // non-hex digit or zero among the hex digits
                    b = 8'($urandom_range(0, 255));
                    if (hex_digit_value(b) >= 0)
                        b = "g";
                    queue_unicode(random_code_point(), $urandom_range(0, 3), b);
                end
            endcase
        // bytes after the final status are ignored
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    endtask

    task automatic drain_results(input int settle);
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- main sequence

    initial
    begin : main
        stim_row_t rows [];
        int        target;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= 8'h00;
        start_req   <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset buffer size of 256
        rows = '{
            '{CH_QUOTE,     1'b1, ROW_NONE,    result_t'('0)},
            '{8'h01,        1'b0, ROW_ONE,     data_result(8'h01)},
            '{8'hFF,        1'b0, ROW_ONE,     data_result(8'hFF)},
            '{CH_BACKSLASH, 1'b0, ROW_NONE,    result_t'('0)},
            '{"u",          1'b0, ROW_NONE,    result_t'('0)},
            '{"f",          1'b0, ROW_NONE,    result_t'('0)},
            '{"F",          1'b0, ROW_NONE,    result_t'('0)},
            '{"f",          1'b0, ROW_NONE,    result_t'('0)},
            '{"F",          1'b0, ROW_PREDICT, result_t'('0)},   // three-byte character
            '{CH_BACKSLASH, 1'b0, ROW_NONE,    result_t'('0)},
            '{"q",          1'b0, ROW_ONE,     status_result(jsu_pkg::ST_PARSE)},
            '{"x",          1'b0, ROW_NONE,    result_t'('0)},   // ignored once done
            '{8'h00,        1'b1, ROW_ONE,     status_result(jsu_pkg::ST_TYPE)},
            '{CH_QUOTE,     1'b1, ROW_NONE,    result_t'('0)},
            '{CH_BACKSLASH, 1'b0, ROW_NONE,    result_t'('0)},
            '{"/",          1'b0, ROW_ONE,     data_result("/")},
            '{CH_QUOTE,     1'b0, ROW_ONE,     status_result(jsu_pkg::ST_OK)},
            '{CH_QUOTE,     1'b1, ROW_NONE,    result_t'('0)},
            '{8'h00,        1'b0, ROW_ONE,     status_result(jsu_pkg::ST_PARSE)},
            '{CH_QUOTE,     1'b1, ROW_NONE,    result_t'('0)},
            '{CH_BACKSLASH, 1'b0, ROW_NONE,    result_t'('0)},
            '{8'h00,        1'b0, ROW_ONE,     status_result(jsu_pkg::ST_PARSE)},
            '{CH_QUOTE,     1'b1, ROW_NONE,    result_t'('0)},
            '{CH_BACKSLASH, 1'b0, ROW_NONE,    result_t'('0)},
            '{"u",          1'b0, ROW_NONE,    result_t'('0)},
            '{"g",          1'b0, ROW_ONE,     status_result(jsu_pkg::ST_PARSE)}
        };
        foreach (rows[i])
        begin
            queue_item(rows[i].data, rows[i].restart, 1'b1);
            row_kinds.push_back(rows[i].kind);
            row_results.push_back(rows[i].res);
        end
        send_pending(1'b1);

        // random part, one buffer size per phase, written while the block is idle
        foreach (buf_settings[p])
        begin
            drain_results(CFG_SETTLE);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= buf_settings[p];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            if (buf_settings[p] == 17'd256)
            begin
                // the hold-off begins before this phase sends its first byte
                hold_request = 1'b1;
                wait (!hold_request);
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                build_string();
                send_pending(items_sent + pending.size() >= target);
            end
        end

        drain_results(END_SETTLE);
        if (errors == 0 && predicted_results.size() == 0)
            $display("json_string_unescape verification clean");
        else
            $display("json_string_unescape verification failed");
        $finish;
    end

endmodule
